### src/tcse_pkg.sv
// tcse_pkg: types, constants and helpers shared by the sgr encoder modules
// no dependencies
`default_nettype none
package tcse_pkg;

  localparam int GLYPH_W         = 32;
  localparam int GLYPH_BYTES     = GLYPH_W / 8;
  localparam int GLYPH_IDX_W     = $clog2(GLYPH_BYTES);
  localparam int MAX_GLYPH_BYTES = 4;
  localparam int GLYPH_CLAMP     = (MAX_GLYPH_BYTES < GLYPH_BYTES) ? MAX_GLYPH_BYTES
                                                                   : GLYPH_BYTES;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_W          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  // reset values of the kept state
  localparam logic [7:0] RST_FORE  = 8'd0;
  localparam logic [7:0] RST_BACK  = 8'd0;
  localparam logic [7:0] RST_ATTR  = 8'd0;
  localparam logic [7:0] RST_FLAGS = 8'h03;

  localparam logic [7:0] ATTR_BOLD      = 8'h01;
  localparam logic [7:0] ATTR_UNDERLINE = 8'h02;
  localparam logic [7:0] ATTR_ITALIC    = 8'h04;
  localparam logic [7:0] ATTR_REVERSE   = 8'h08;
  localparam logic [7:0] FLAG_DEF_FORE  = 8'h01;
  localparam logic [7:0] FLAG_DEF_BACK  = 8'h02;

  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LBR   = 8'h5B;  // '['
  localparam logic [7:0] CH_M     = 8'h6D;  // 'm'
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_FOUR  = 8'h34;
  localparam logic [7:0] CH_FIVE  = 8'h35;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_EIGHT = 8'h38;

  // output segments, emitted in this order
  typedef enum logic [3:0] {
    SEG_PSTART = 4'd0,
    SEG_RESET  = 4'd1,
    SEG_BOLD   = 4'd2,
    SEG_UL     = 4'd3,
    SEG_ITAL   = 4'd4,
    SEG_REV    = 4'd5,
    SEG_FORE   = 4'd6,
    SEG_BACK   = 4'd7,
    SEG_BODY   = 4'd8,
    SEG_END    = 4'd9
  } seg_t;
  localparam int NUM_SEGS = 10;

  typedef struct packed {
    logic [2:0][3:0] dig;   // dig[0] printed first
    logic [1:0]      nd;
  } dec_t;

  typedef struct packed {
    logic [NUM_SEGS-1:0] seg_mask;
    dec_t                fore;
    dec_t                back;
    logic [GLYPH_W-1:0]  glyph;
    logic [2:0]          glyph_n;
  } job_t;

  function automatic dec_t to_dec(input logic [7:0] v);
    logic [3:0]  h;
    logic [7:0]  r;
    logic [14:0] prod;
    logic [3:0]  t;
    logic [3:0]  u;
    dec_t        d;
    h = (v >= 8'd200) ? 4'd2 : ((v >= 8'd100) ? 4'd1 : 4'd0);
    r = v - 8'(h * 8'd100);
    // r < 100, so r*205 >> 11 is r / 10
    prod = 15'(r[6:0]) * 15'd205;
    t = prod[14:11];
    u = 4'(r - 8'(t * 8'd10));
    if (v >= 8'd100) begin
      d.dig = {u, t, h};
      d.nd  = 2'd3;
    end else if (v >= 8'd10) begin
      d.dig = {4'd0, u, t};
      d.nd  = 2'd2;
    end else begin
      d.dig = {4'd0, 4'd0, u};
      d.nd  = 2'd1;
    end
    return d;
  endfunction

endpackage
`default_nettype wire

### src/tcse_cell_if.sv
// tcse_cell_if: valid/ready channel carrying one terminal cell
// no dependencies
`default_nettype none
interface tcse_cell_if;
  logic        valid;
  logic        ready;
  logic        pane_start;
  logic        row_start;
  logic        pane_end;
  logic        no_line;
  logic [31:0] glyph_bytes;
  logic [2:0]  glyph_len;
  logic [7:0]  fore_colour;
  logic [7:0]  back_colour;
  logic [7:0]  attr_bits;
  logic [7:0]  colour_flags;
  logic [1:0]  glyph_columns;

  modport source (output valid, pane_start, row_start, pane_end, no_line, glyph_bytes,
                  glyph_len, fore_colour, back_colour, attr_bits, colour_flags,
                  glyph_columns, input ready);
  modport sink (input valid, pane_start, row_start, pane_end, no_line, glyph_bytes,
                glyph_len, fore_colour, back_colour, attr_bits, colour_flags,
                glyph_columns, output ready);
endinterface
`default_nettype wire

### src/tcse_byte_if.sv
// tcse_byte_if: valid/ready channel carrying one output byte
// no dependencies
`default_nettype none
interface tcse_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink (input valid, out_byte, last_byte, output ready);
endinterface
`default_nettype wire

### src/tcse_front.sv
// tcse_front: accepts cells, tracks kept attributes and skip count, builds jobs
// depends on tcse_pkg, tcse_cell_if
`default_nettype none
module tcse_front (
  input  wire logic          clk,
  input  wire logic          rst,
  tcse_cell_if.sink          cell_in,
  output tcse_pkg::job_t     job,
  output logic               job_valid,
  input  wire logic          job_ready
);
  import tcse_pkg::*;

  logic [7:0] prev_fore, prev_fore_next;
  logic [7:0] prev_back, prev_back_next;
  logic [7:0] prev_attr, prev_attr_next;
  logic [7:0] prev_flags, prev_flags_next;
  logic [1:0] cells_to_skip, cells_to_skip_next;

  logic       accept;
  logic [7:0] base_fore, base_back, base_attr, base_flags;
  logic [1:0] base_skip;
  logic       changed;
  logic       glyph_ok;
  logic [2:0] clamp_n;

  assign cell_in.ready = job_ready;
  assign accept        = cell_in.valid & cell_in.ready;

  always_comb begin
    base_fore  = cell_in.pane_start ? RST_FORE  : prev_fore;
    base_back  = cell_in.pane_start ? RST_BACK  : prev_back;
    base_attr  = cell_in.pane_start ? RST_ATTR  : prev_attr;
    base_flags = cell_in.pane_start ? RST_FLAGS : prev_flags;
    base_skip  = (cell_in.pane_start | cell_in.row_start) ? 2'd0 : cells_to_skip;

    changed = (cell_in.fore_colour != base_fore) || (cell_in.back_colour != base_back) ||
              (cell_in.attr_bits != base_attr) || (cell_in.colour_flags != base_flags);
    glyph_ok = (cell_in.glyph_len != 3'd0) && (cell_in.glyph_bytes[7:0] != 8'd0);
    clamp_n  = (cell_in.glyph_len > 3'(GLYPH_CLAMP)) ? 3'(GLYPH_CLAMP) : cell_in.glyph_len;

    prev_fore_next     = base_fore;
    prev_back_next     = base_back;
    prev_attr_next     = base_attr;
    prev_flags_next    = base_flags;
    cells_to_skip_next = base_skip;

    job          = '0;
    job.fore     = to_dec(cell_in.fore_colour);
    job.back     = to_dec(cell_in.back_colour);
    job.glyph    = {{(GLYPH_W-8){1'b0}}, CH_SPACE};
    job.glyph_n  = 3'd1;
    job.seg_mask[SEG_PSTART] = cell_in.pane_start;
    job.seg_mask[SEG_END]    = cell_in.pane_end;

    if (cell_in.no_line) begin
      job.seg_mask[SEG_BODY] = 1'b1;
      cells_to_skip_next     = 2'd0;
    end else if (base_skip != 2'd0) begin
      // covered by a wide glyph
      cells_to_skip_next = base_skip - 2'd1;
    end else begin
      if (changed) begin
        job.seg_mask[SEG_RESET] = 1'b1;
        job.seg_mask[SEG_BOLD]  = |(cell_in.attr_bits & ATTR_BOLD);
        job.seg_mask[SEG_UL]    = |(cell_in.attr_bits & ATTR_UNDERLINE);
        job.seg_mask[SEG_ITAL]  = |(cell_in.attr_bits & ATTR_ITALIC);
        job.seg_mask[SEG_REV]   = |(cell_in.attr_bits & ATTR_REVERSE);
        job.seg_mask[SEG_FORE]  = ~|(cell_in.colour_flags & FLAG_DEF_FORE);
        job.seg_mask[SEG_BACK]  = ~|(cell_in.colour_flags & FLAG_DEF_BACK);
        prev_fore_next  = cell_in.fore_colour;
        prev_back_next  = cell_in.back_colour;
        prev_attr_next  = cell_in.attr_bits;
        prev_flags_next = cell_in.colour_flags;
      end
      job.seg_mask[SEG_BODY] = 1'b1;
      if (glyph_ok) begin
        job.glyph          = cell_in.glyph_bytes;
        job.glyph_n        = clamp_n;
        cells_to_skip_next = (cell_in.glyph_columns == 2'd0) ? 2'd0
                                                             : cell_in.glyph_columns - 2'd1;
      end else begin
        cells_to_skip_next = 2'd0;
      end
    end
  end

  // covered cells with no pane marks produce nothing and are dropped here
  assign job_valid = accept & (|job.seg_mask);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_fore     <= RST_FORE;
      prev_back     <= RST_BACK;
      prev_attr     <= RST_ATTR;
      prev_flags    <= RST_FLAGS;
      cells_to_skip <= 2'd0;
    end else if (accept) begin
      prev_fore     <= prev_fore_next;
      prev_back     <= prev_back_next;
      prev_attr     <= prev_attr_next;
      prev_flags    <= prev_flags_next;
      cells_to_skip <= cells_to_skip_next;
    end
  end

endmodule
`default_nettype wire

### src/tcse_queue.sv
// tcse_queue: short job queue between the front and back parts
// depends on tcse_pkg
`default_nettype none
module tcse_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire tcse_pkg::job_t  wr_job,
  input  wire logic            wr_valid,
  output logic                 wr_ready,
  output tcse_pkg::job_t       rd_job,
  output logic                 rd_valid,
  input  wire logic            rd_ready
);
  import tcse_pkg::*;

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign wr_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_job   = mem[rd_ptr];
  assign push     = wr_valid & wr_ready;
  assign pop      = rd_valid & rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule
`default_nettype wire

### src/tcse_back.sv
// tcse_back: walks a job's segments and emits one byte per cycle while the output accepts
// depends on tcse_pkg, tcse_byte_if
`default_nettype none
module tcse_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire tcse_pkg::job_t  q_job,
  input  wire logic            q_valid,
  output logic                 q_ready,
  tcse_byte_if.source          byte_out
);
  import tcse_pkg::*;

  job_t                cur;
  logic                cur_valid;
  logic [NUM_SEGS-1:0] rem;
  logic [3:0]          pos;
  logic [7:0]          o_byte;
  logic                o_last;
  logic                o_valid;

  seg_t                seg;
  logic [NUM_SEGS-1:0] seg_bit;
  logic [NUM_SEGS-1:0] rem_next;
  logic [3:0]          seg_len;
  logic [7:0]          byte_val;
  logic                emit;
  logic                seg_done;
  logic                job_done;
  logic [1:0]          dig_idx;
  dec_t                dsel;
  logic [7:0]          code;
  logic                pop;

  // lowest pending segment
  always_comb begin
    seg     = SEG_END;
    seg_bit = '0;
    for (int i = NUM_SEGS - 1; i >= 0; i--) begin
      if (rem[i]) begin
        seg = seg_t'(i);
      end
    end
    seg_bit[seg] = 1'b1;
  end

  always_comb begin
    dsel    = (seg == SEG_FORE) ? cur.fore : cur.back;
    dig_idx = 2'(pos - 4'd7);
    case (seg)
      SEG_BOLD: code = CH_ONE;
      SEG_UL:   code = CH_FOUR;
      SEG_ITAL: code = CH_THREE;
      SEG_REV:  code = CH_SEVEN;
      SEG_FORE: code = CH_THREE;
      SEG_BACK: code = CH_FOUR;
      default:  code = CH_ZERO;
    endcase

    case (seg)
      SEG_FORE, SEG_BACK: seg_len = 4'd8 + 4'(dsel.nd);
      SEG_BODY:           seg_len = 4'(cur.glyph_n);
      default:            seg_len = 4'd4;
    endcase

    case (seg)
      SEG_BODY: begin
        byte_val = cur.glyph[8*pos[GLYPH_IDX_W-1:0] +: 8];
      end
      SEG_FORE, SEG_BACK: begin
        case (pos)
          4'd0:    byte_val = CH_ESC;
          4'd1:    byte_val = CH_LBR;
          4'd2:    byte_val = code;
          4'd3:    byte_val = CH_EIGHT;
          4'd4:    byte_val = CH_SEMI;
          4'd5:    byte_val = CH_FIVE;
          4'd6:    byte_val = CH_SEMI;
          default: begin
            if (pos == seg_len - 4'd1) begin
              byte_val = CH_M;
            end else begin
              byte_val = CH_ZERO + 8'(dsel.dig[dig_idx]);
            end
          end
        endcase
      end
      default: begin
        case (pos)
          4'd0:    byte_val = CH_ESC;
          4'd1:    byte_val = CH_LBR;
          4'd2:    byte_val = code;
          default: byte_val = CH_M;
        endcase
      end
    endcase
  end

  assign emit     = cur_valid & (~o_valid | byte_out.ready);
  assign seg_done = (pos == seg_len - 4'd1);
  assign rem_next = rem & ~seg_bit;
  assign job_done = seg_done & (rem_next == '0);
  assign pop      = q_valid & (~cur_valid | (emit & job_done));
  assign q_ready  = ~cur_valid | (emit & job_done);

  assign byte_out.valid     = o_valid;
  assign byte_out.out_byte  = o_byte;
  assign byte_out.last_byte = o_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      rem       <= '0;
      pos       <= '0;
      o_valid   <= 1'b0;
    end else begin
      if (emit) begin
        o_valid <= 1'b1;
      end else if (byte_out.ready) begin
        o_valid <= 1'b0;
      end

      if (pop) begin
        cur_valid <= 1'b1;
        rem       <= q_job.seg_mask;
        pos       <= '0;
      end else if (emit) begin
        if (job_done) begin
          cur_valid <= 1'b0;
          rem       <= '0;
          pos       <= '0;
        end else if (seg_done) begin
          rem <= rem_next;
          pos <= '0;
        end else begin
          pos <= pos + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_job;
    end
    if (emit) begin
      o_byte <= byte_val;
      o_last <= job_done;
    end
  end

endmodule
`default_nettype wire

### src/terminal_cell_sgr_encoder_top.sv
// terminal_cell_sgr_encoder_top: terminal cells in, ANSI SGR byte stream out
// depends on tcse_pkg, tcse_cell_if, tcse_byte_if, tcse_front, tcse_queue, tcse_back
//
//   channel    dir  handshake      payload
//   cell_in    in   valid/ready    pane/row marks, glyph, colours, attrs, flags, columns
//   byte_out   out  valid/ready    out_byte, last_byte
//
// the front takes one cell per cycle while the job queue has room
// the back emits one byte per cycle while the output accepts; a cell causes
// 1 to 54 bytes, and covered cells with no pane marks cause none
// an output register holds each byte; the back stalls while a byte waits
// rst is synchronous: kept colours/attributes return to defaults, queue empties
`default_nettype none
module terminal_cell_sgr_encoder_top (
  input  wire logic clk,
  input  wire logic rst,
  tcse_cell_if.sink   cell_in,
  tcse_byte_if.source byte_out
);
  import tcse_pkg::*;

  job_t fj;
  logic fj_valid;
  logic fj_ready;
  job_t qj;
  logic qj_valid;
  logic qj_ready;

  tcse_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cell_in   (cell_in),
    .job       (fj),
    .job_valid (fj_valid),
    .job_ready (fj_ready)
  );

  tcse_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_job   (fj),
    .wr_valid (fj_valid),
    .wr_ready (fj_ready),
    .rd_job   (qj),
    .rd_valid (qj_valid),
    .rd_ready (qj_ready)
  );

  tcse_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_job    (qj),
    .q_valid  (qj_valid),
    .q_ready  (qj_ready),
    .byte_out (byte_out)
  );

endmodule
`default_nettype wire

### tb/sv/testbench.sv
// testbench: self-checking regression for terminal_cell_sgr_encoder_top
// depends on tcse_pkg, tcse_cell_if, tcse_byte_if and the encoder rtl
// an in-bench model of the sgr encoder predicts the byte stream of every accepted cell
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tcse_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 12;
  localparam int RANDOM_CELLS   = 110;
  localparam int MAX_REPORTS    = 40;

  typedef struct packed {
    logic        pane_start;
    logic        row_start;
    logic        pane_end;
    logic        no_line;
    logic [31:0] glyph_bytes;
    logic [2:0]  glyph_len;
    logic [7:0]  fore_colour;
    logic [7:0]  back_colour;
    logic [7:0]  attr_bits;
    logic [7:0]  colour_flags;
    logic [1:0]  glyph_columns;
  } cell_t;

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } out_item_t;

  logic clk;
  logic rst;

  tcse_cell_if cell_in ();
  tcse_byte_if byte_out ();

  terminal_cell_sgr_encoder_top dut (
    .clk(clk),
    .rst(rst),
    .cell_in(cell_in),
    .byte_out(byte_out)
  );

  // kept terminal state of the model
  logic [7:0] kept_fore;
  logic [7:0] kept_back;
  logic [7:0] kept_attr;
  logic [7:0] kept_flags;
  logic [1:0] skip_count;

  logic [7:0] cell_bytes[$];
  out_item_t  pending_bytes[$];

  int  error_count   = 0;
  int  sent_cells    = 0;
  int  idle_cycles   = 0;
  bit  idle_enable   = 0;
  bit  hold_off_req  = 0;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic int gap_cycles();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  function automatic void put_sgr(input logic [7:0] code);
    cell_bytes.push_back(CH_ESC);
    cell_bytes.push_back(CH_LBR);
    cell_bytes.push_back(code);
    cell_bytes.push_back(CH_M);
  endfunction

  function automatic void put_colour(input logic [7:0] lead, input logic [7:0] idx);
    cell_bytes.push_back(CH_ESC);
    cell_bytes.push_back(CH_LBR);
    cell_bytes.push_back(lead);
    cell_bytes.push_back(CH_EIGHT);
    cell_bytes.push_back(CH_SEMI);
    cell_bytes.push_back(CH_FIVE);
    cell_bytes.push_back(CH_SEMI);
    // decimal with no leading zeros
    if (idx >= 8'd100) cell_bytes.push_back(8'(CH_ZERO + idx / 8'd100));
    if (idx >= 8'd10) cell_bytes.push_back(8'(CH_ZERO + (idx / 8'd10) % 8'd10));
    cell_bytes.push_back(8'(CH_ZERO + idx % 8'd10));
    cell_bytes.push_back(CH_M);
  endfunction

  function automatic void reset_kept_state();
    kept_fore  = RST_FORE;
    kept_back  = RST_BACK;
    kept_attr  = RST_ATTR;
    kept_flags = RST_FLAGS;
    skip_count = 2'd0;
  endfunction

  // works out the bytes one cell causes and queues them
  function automatic void predict_cell(input cell_t c);
    int n;
    out_item_t item;
    cell_bytes.delete();
    if (c.pane_start) begin
      reset_kept_state();
      put_sgr(CH_ZERO);
    end
    if (c.row_start) skip_count = 2'd0;

    if (c.no_line) begin
      skip_count = 2'd0;
      cell_bytes.push_back(CH_SPACE);
    end else if (skip_count != 2'd0) begin
      skip_count = skip_count - 2'd1;
    end else begin
      if (c.fore_colour != kept_fore || c.back_colour != kept_back ||
          c.attr_bits != kept_attr || c.colour_flags != kept_flags) begin
        put_sgr(CH_ZERO);
        if ((c.attr_bits & ATTR_BOLD) != 8'd0) put_sgr(CH_ONE);
        if ((c.attr_bits & ATTR_UNDERLINE) != 8'd0) put_sgr(CH_FOUR);
        if ((c.attr_bits & ATTR_ITALIC) != 8'd0) put_sgr(CH_THREE);
        if ((c.attr_bits & ATTR_REVERSE) != 8'd0) put_sgr(CH_SEVEN);
        if ((c.colour_flags & FLAG_DEF_FORE) == 8'd0) put_colour(CH_THREE, c.fore_colour);
        if ((c.colour_flags & FLAG_DEF_BACK) == 8'd0) put_colour(CH_FOUR, c.back_colour);
        kept_fore  = c.fore_colour;
        kept_back  = c.back_colour;
        kept_attr  = c.attr_bits;
        kept_flags = c.colour_flags;
      end
      if (c.glyph_len != 3'd0 && c.glyph_bytes[7:0] != 8'd0) begin
        n = c.glyph_len;
        if (n > MAX_GLYPH_BYTES) n = MAX_GLYPH_BYTES;
        if (n > GLYPH_BYTES) n = GLYPH_BYTES;
        for (int i = 0; i < n; i++) cell_bytes.push_back(c.glyph_bytes[8*i +: 8]);
        skip_count = (c.glyph_columns == 2'd0) ? 2'd0 : c.glyph_columns - 2'd1;
      end else begin
        cell_bytes.push_back(CH_SPACE);
        skip_count = 2'd0;
      end
    end

    if (c.pane_end) put_sgr(CH_ZERO);

    foreach (cell_bytes[i]) begin
      item.data    = cell_bytes[i];
      item.is_last = (i == cell_bytes.size() - 1);
      pending_bytes.push_back(item);
    end
  endfunction

  function automatic void report_mismatch(input string field, input int want, input int got);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $error("%s: expected %0h, actual %0h", field, want, got);
  endfunction

  // predict on accepted cells, then check accepted bytes against the oldest expectation
  always @(posedge clk) begin
    cell_t     seen;
    out_item_t want;
    if (!rst) begin
      if (cell_in.valid && cell_in.ready) begin
        seen.pane_start    = cell_in.pane_start;
        seen.row_start     = cell_in.row_start;
        seen.pane_end      = cell_in.pane_end;
        seen.no_line       = cell_in.no_line;
        seen.glyph_bytes   = cell_in.glyph_bytes;
        seen.glyph_len     = cell_in.glyph_len;
        seen.fore_colour   = cell_in.fore_colour;
        seen.back_colour   = cell_in.back_colour;
        seen.attr_bits     = cell_in.attr_bits;
        seen.colour_flags  = cell_in.colour_flags;
        seen.glyph_columns = cell_in.glyph_columns;
        predict_cell(seen);
      end
      if (byte_out.valid && byte_out.ready) begin
        if (pending_bytes.size() == 0) begin
          report_mismatch("unexpected out_byte", -1, byte_out.out_byte);
        end else begin
          want = pending_bytes.pop_front();
          if (byte_out.out_byte !== want.data)
            report_mismatch("out_byte", want.data, byte_out.out_byte);
          if (byte_out.last_byte !== want.is_last)
            report_mismatch("last_byte", want.is_last, byte_out.last_byte);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cell_in.valid && cell_in.ready) || (byte_out.valid && byte_out.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("terminal_cell_sgr_encoder_top regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // output side: random stalls, plus one long hold-off on request
  initial begin
    byte_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 0;
        byte_out.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (idle_enable && $urandom_range(0, 3) == 0) begin
        byte_out.ready <= 1'b0;
        repeat (gap_cycles() - 1) @(negedge clk);
      end else begin
        byte_out.ready <= 1'b1;
      end
    end
  end

  task automatic send_cell(input cell_t c);
    int gap;
    gap = (idle_enable && $urandom_range(0, 3) == 0) ? gap_cycles() : 0;
    if (gap > 0) begin
      @(negedge clk);
      cell_in.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cell_in.valid         <= 1'b1;
    cell_in.pane_start    <= c.pane_start;
    cell_in.row_start     <= c.row_start;
    cell_in.pane_end      <= c.pane_end;
    cell_in.no_line       <= c.no_line;
    cell_in.glyph_bytes   <= c.glyph_bytes;
    cell_in.glyph_len     <= c.glyph_len;
    cell_in.fore_colour   <= c.fore_colour;
    cell_in.back_colour   <= c.back_colour;
    cell_in.attr_bits     <= c.attr_bits;
    cell_in.colour_flags  <= c.colour_flags;
    cell_in.glyph_columns <= c.glyph_columns;
    do @(posedge clk); while (!(cell_in.valid && cell_in.ready));
    sent_cells++;
  endtask

  task automatic drain_output();
    @(negedge clk);
    cell_in.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic cell_t blank_cell(input logic [7:0] ch);
    cell_t c;
    c               = '0;
    c.glyph_bytes   = {24'd0, ch};
    c.glyph_len     = 3'd1;
    c.fore_colour   = RST_FORE;
    c.back_colour   = RST_BACK;
    c.attr_bits     = RST_ATTR;
    c.colour_flags  = RST_FLAGS;
    c.glyph_columns = 2'd1;
    return c;
  endfunction

  function automatic cell_t random_style(input cell_t c);
    c.fore_colour  = 8'($urandom);
    c.back_colour  = 8'($urandom);
    c.attr_bits    = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
    c.colour_flags = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    return c;
  endfunction

  function automatic cell_t with_random_glyph(input cell_t c);
    int pick;
    pick          = $urandom_range(0, 19);
    c.glyph_bytes = $urandom();
    c.glyph_columns = 2'($urandom_range(0, 3));
    if (pick < 11) begin
      c.glyph_len         = 3'd1;
      c.glyph_bytes[7:0]  = 8'($urandom_range(33, 126));
      c.glyph_columns     = 2'($urandom_range(0, 1));
    end else if (pick < 15) begin
      // multi-byte lead byte, always wide
      c.glyph_len         = 3'($urandom_range(2, 4));
      c.glyph_bytes[7:0]  = 8'($urandom_range(8'hC2, 8'hF4));
      c.glyph_columns     = 2'($urandom_range(2, 3));
    end else if (pick < 17) begin
      c.glyph_len = 3'd0;
    end else if (pick == 17) begin
      c.glyph_len        = 3'($urandom_range(1, 7));
      c.glyph_bytes[7:0] = 8'd0;
    end else begin
      c.glyph_len = 3'($urandom_range(5, 7));
    end
    return c;
  endfunction

  task automatic test_plain_cells();
    cell_t c;
    c = blank_cell("A");
    c.pane_start = 1'b1;
    send_cell(c);
    c = blank_cell("B");
    c.glyph_len = 3'd0;
    send_cell(c);
    // zero first byte reads as empty
    c = blank_cell(8'd0);
    c.glyph_bytes = 32'h0000_4100;
    c.glyph_len   = 3'd2;
    send_cell(c);
    c = blank_cell("C");
    c.no_line     = 1'b1;
    c.row_start   = 1'b1;
    c.fore_colour = 8'hFF;
    send_cell(c);
    drain_output();
  endtask

  task automatic test_colour_attributes();
    cell_t c;
    c = blank_cell("a");
    c.attr_bits    = ATTR_BOLD | ATTR_UNDERLINE | ATTR_ITALIC | ATTR_REVERSE;
    c.colour_flags = 8'd0;
    c.back_colour  = 8'd255;
    send_cell(c);
    // upper attribute and flag bits force a change but give no codes
    c.attr_bits    = 8'hF0;
    c.colour_flags = 8'hFC;
    c.fore_colour  = 8'd9;
    c.back_colour  = 8'd10;
    send_cell(c);
    c.attr_bits    = 8'd0;
    c.colour_flags = FLAG_DEF_FORE;
    c.fore_colour  = 8'd99;
    c.back_colour  = 8'd100;
    send_cell(c);
    c.colour_flags = FLAG_DEF_BACK;
    c.fore_colour  = 8'd100;
    c.back_colour  = 8'd99;
    send_cell(c);
    send_cell(c);
    c.attr_bits    = ATTR_BOLD | ATTR_ITALIC;
    c.colour_flags = 8'hFF;
    c.fore_colour  = 8'd255;
    c.back_colour  = 8'd0;
    c.pane_end     = 1'b1;
    send_cell(c);
    drain_output();
  endtask

  task automatic test_glyph_lengths();
    cell_t c;
    c = blank_cell(8'd0);
    c.glyph_bytes = 32'hFF00_00C3;
    c.glyph_len   = 3'd4;
    send_cell(c);
    c.glyph_bytes = 32'h8899_AABB;
    c.glyph_len   = 3'd7;
    send_cell(c);
    c.glyph_bytes = 32'h7F80_0141;
    c.glyph_len   = 3'd5;
    send_cell(c);
    c.glyph_bytes = 32'h5500_A2E2;
    c.glyph_len   = 3'd3;
    send_cell(c);
    drain_output();
  endtask

  task automatic test_wide_glyphs();
    cell_t c;
    c = blank_cell("W");
    c.pane_start    = 1'b1;
    c.glyph_columns = 2'd3;
    send_cell(c);
    c = blank_cell("x");
    send_cell(c);
    // covered cell still closes the pane
    c.pane_end = 1'b1;
    send_cell(c);
    c = blank_cell("W");
    c.pane_start    = 1'b1;
    c.glyph_columns = 2'd2;
    send_cell(c);
    c = blank_cell("r");
    c.row_start     = 1'b1;
    c.glyph_columns = 2'd0;
    send_cell(c);
    c = blank_cell("W");
    c.glyph_columns = 2'd2;
    send_cell(c);
    c = blank_cell("n");
    c.no_line = 1'b1;
    send_cell(c);
    c = blank_cell("W");
    c.glyph_columns = 2'd2;
    send_cell(c);
    c = blank_cell("p");
    c.pane_start = 1'b1;
    send_cell(c);
    // empty glyph ignores its column count
    c = blank_cell("e");
    c.glyph_len     = 3'd0;
    c.glyph_columns = 2'd3;
    send_cell(c);
    c = blank_cell("W");
    c.glyph_columns = 2'd3;
    send_cell(c);
    c = blank_cell("s");
    send_cell(c);
    drain_output();
  endtask

  task automatic test_output_backpressure();
    cell_t c;
    idle_enable  = 0;
    hold_off_req = 1;
    c = blank_cell("h");
    for (int i = 0; i < 24; i++) begin
      c = with_random_glyph(random_style(c));
      c.pane_start = (i == 0);
      c.pane_end   = (i == 23);
      send_cell(c);
    end
    drain_output();
  endtask

  task automatic send_random_pane(input int rows, input int cols);
    cell_t c;
    cell_t style;
    style = random_style(blank_cell(" "));
    for (int r = 0; r < rows; r++) begin
      if ($urandom_range(0, 7) == 0) begin
        c = with_random_glyph(style);
        c.no_line    = 1'b1;
        c.row_start  = 1'b1;
        c.pane_start = (r == 0);
        c.pane_end   = (r == rows - 1);
        send_cell(c);
      end else begin
        for (int k = 0; k < cols; k++) begin
          if ($urandom_range(0, 3) == 0) style = random_style(style);
          c = with_random_glyph(style);
          c.no_line    = 1'b0;
          c.row_start  = (k == 0);
          c.pane_start = (r == 0 && k == 0);
          c.pane_end   = (r == rows - 1 && k == cols - 1);
          send_cell(c);
        end
      end
    end
  endtask

  task automatic send_noise(input int count);
    cell_t       c;
    logic [95:0] noise;
    for (int i = 0; i < count; i++) begin
      noise = {$urandom(), $urandom(), $urandom()};
      c     = noise[$bits(cell_t)-1:0];
      send_cell(c);
    end
  endtask

  task automatic test_random_panes();
    int start;
    start = sent_cells;
    while (sent_cells - start < RANDOM_CELLS) begin
      idle_enable = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) == 0) send_noise($urandom_range(3, 8));
      else send_random_pane($urandom_range(1, 4), $urandom_range(1, 8));
    end
    drain_output();
  endtask

  initial begin
    rst                   = 1'b1;
    cell_in.valid         = 1'b0;
    cell_in.pane_start    = 1'b0;
    cell_in.row_start     = 1'b0;
    cell_in.pane_end      = 1'b0;
    cell_in.no_line       = 1'b0;
    cell_in.glyph_bytes   = 32'd0;
    cell_in.glyph_len     = 3'd0;
    cell_in.fore_colour   = 8'd0;
    cell_in.back_colour   = 8'd0;
    cell_in.attr_bits     = 8'd0;
    cell_in.colour_flags  = 8'd0;
    cell_in.glyph_columns = 2'd0;
    reset_kept_state();
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    idle_enable = 1;
    test_plain_cells();
    test_colour_attributes();
    test_glyph_lengths();
    test_wide_glyphs();
    test_output_backpressure();
    test_random_panes();

    if (error_count == 0 && pending_bytes.size() == 0) begin
      $display("terminal_cell_sgr_encoder_top regression: pass");
    end else begin
      $display("terminal_cell_sgr_encoder_top regression: fail");
    end
    $finish;
  end

endmodule
